@@ rtl/rari_pkg.sv @@
// Shared types and constants for the ray / axis-aligned rectangle intersection unit.
package rari_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int UV_BITS       = 16;
    localparam int COORD_W       = 32;
    localparam int MAT_W         = 16;
    localparam int ADDR_W        = 5;
    localparam int DIV_DW        = 33;

    // Configuration register indexes (byte address = 4 * index)
    typedef enum logic [2:0] {
        REG_PLANE_AXIS   = 3'd0,
        REG_PLANE_OFFSET = 3'd1,
        REG_BOUND_A_LOW  = 3'd2,
        REG_BOUND_A_HIGH = 3'd3,
        REG_BOUND_B_LOW  = 3'd4,
        REG_BOUND_B_HIGH = 3'd5,
        REG_MATERIAL_ID  = 3'd6,
        REG_UNUSED       = 3'd7
    } reg_idx_t;

    // Normal-axis codes
    typedef enum logic [1:0] {
        AXIS_X  = 2'd0,
        AXIS_Y  = 2'd1,
        AXIS_Z  = 2'd2,
        AXIS_Z2 = 2'd3
    } axis_t;

    // Side data carried alongside the t divider
    typedef struct packed {
        logic signed [COORD_W-1:0] oa;
        logic signed [COORD_W-1:0] ob;
        logic signed [COORD_W-1:0] da;
        logic signed [COORD_W-1:0] db;
        logic signed [COORD_W-1:0] tlo;
        logic signed [COORD_W-1:0] thi;
        axis_t                     axis;
        logic                      neg;
        logic                      dzero;
        logic                      front;
    } tpay_t;

    // Side data carried alongside the u divider
    typedef struct packed {
        logic [COORD_W-1:0] tv;
        logic [COORD_W-1:0] hx;
        logic [COORD_W-1:0] hy;
        logic [COORD_W-1:0] hz;
        logic               front;
        logic               za;
        logic               ok;
    } upay_t;

    // Saturate a 65-bit signed value to 32 bits
    function automatic logic [COORD_W-1:0] sat32(input logic signed [64:0] v);
        logic [COORD_W-1:0] r;
        if (v[64:31] == '0 || v[64:31] == '1)
        begin
            r = v[31:0];
        end
        else if (v[64])
        begin
            r = {1'b1, {(COORD_W-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(COORD_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

@@ rtl/ray_axis_rect_intersect_unit.sv @@
// Top level of the ray / axis-aligned rectangle intersection unit.
// One ray is taken per clock cycle while the pipeline advances, and one result leaves
// per ray, in order. The t divider is bit-per-stage (33 + FRAC_BITS stages) and the
// u/v dividers have 17 stages; values are Q16.16 at the default FRAC_BITS. The whole
// pipeline advances whenever the output register is empty or being taken, so
// s_tready follows m_tready combinationally. A miss gives all-zero fields.
// Configuration must be written over APB only while no ray is in flight; unenforced.
module ray_axis_rect_intersect_unit #(
    parameter int FRAC_BITS = rari_pkg::FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // APB configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rari_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    // ray input
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_lower, t_upper
    input  logic [255:0]                s_tdata,
    // result output
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // t_value, u_coord, v_coord, hit_x, hit_y, hit_z, front_face, hit_material, pad
    output logic [183:0]                m_tdata,
    // hit
    output logic                        m_tuser
);

    localparam int QT  = 33 + FRAC_BITS;
    localparam int QUV = rari_pkg::UV_BITS + 1;
    localparam int TPW = $bits(rari_pkg::tpay_t);
    localparam int UPW = $bits(rari_pkg::upay_t);

    logic adv;

    // ---------------- configuration registers ----------------
    logic [1:0]         axis_reg;
    logic signed [31:0] offset_reg;
    logic signed [31:0] alo_reg;
    logic signed [31:0] ahi_reg;
    logic signed [31:0] blo_reg;
    logic signed [31:0] bhi_reg;
    logic [15:0]        mat_reg;
    rari_pkg::reg_idx_t widx;

    assign widx   = rari_pkg::reg_idx_t'(paddr[4:2]);
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_reg   <= rari_pkg::AXIS_Z;
            offset_reg <= '0;
            alo_reg    <= '0;
            ahi_reg    <= 32'sd65536;
            blo_reg    <= '0;
            bhi_reg    <= 32'sd65536;
            mat_reg    <= '0;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (widx)
                rari_pkg::REG_PLANE_AXIS:   axis_reg   <= pwdata[1:0];
                rari_pkg::REG_PLANE_OFFSET: offset_reg <= pwdata;
                rari_pkg::REG_BOUND_A_LOW:  alo_reg    <= pwdata;
                rari_pkg::REG_BOUND_A_HIGH: ahi_reg    <= pwdata;
                rari_pkg::REG_BOUND_B_LOW:  blo_reg    <= pwdata;
                rari_pkg::REG_BOUND_B_HIGH: bhi_reg    <= pwdata;
                rari_pkg::REG_MATERIAL_ID:  mat_reg    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        unique case (widx)
            rari_pkg::REG_PLANE_AXIS:   prdata = {30'd0, axis_reg};
            rari_pkg::REG_PLANE_OFFSET: prdata = offset_reg;
            rari_pkg::REG_BOUND_A_LOW:  prdata = alo_reg;
            rari_pkg::REG_BOUND_A_HIGH: prdata = ahi_reg;
            rari_pkg::REG_BOUND_B_LOW:  prdata = blo_reg;
            rari_pkg::REG_BOUND_B_HIGH: prdata = bhi_reg;
            rari_pkg::REG_MATERIAL_ID:  prdata = {16'd0, mat_reg};
            default:                    prdata = '0;
        endcase
    end

    // ---------------- stage 0: input register ----------------
    logic         s0_vld_reg;
    logic [255:0] s0_data_reg;

    assign s_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s0_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_data_reg <= s_tdata;
        end
    end

    // ---------------- stage 1: axis select, numerator and divisor ----------------
    logic signed [31:0] ox, oy, oz, dx, dy, dz;
    logic signed [31:0] on, dn;
    rari_pkg::tpay_t    s1_pay;
    rari_pkg::axis_t    s1_axis;
    logic signed [32:0] s1_num;
    logic [32:0]        s1_mag;
    logic [31:0]        s1_dmag;

    assign ox = s0_data_reg[31:0];
    assign oy = s0_data_reg[63:32];
    assign oz = s0_data_reg[95:64];
    assign dx = s0_data_reg[127:96];
    assign dy = s0_data_reg[159:128];
    assign dz = s0_data_reg[191:160];

    always_comb
    begin
        unique case (axis_reg)
            rari_pkg::AXIS_X:
            begin
                s1_axis = rari_pkg::AXIS_X;
                on = ox; dn = dx;
                s1_pay.oa = oy; s1_pay.ob = oz; s1_pay.da = dy; s1_pay.db = dz;
            end
            rari_pkg::AXIS_Y:
            begin
                s1_axis = rari_pkg::AXIS_Y;
                on = oy; dn = dy;
                s1_pay.oa = ox; s1_pay.ob = oz; s1_pay.da = dx; s1_pay.db = dz;
            end
            default:
            begin
                s1_axis = rari_pkg::AXIS_Z;
                on = oz; dn = dz;
                s1_pay.oa = ox; s1_pay.ob = oy; s1_pay.da = dx; s1_pay.db = dy;
            end
        endcase
        s1_num       = {offset_reg[31], offset_reg} - {on[31], on};
        s1_mag       = s1_num[32] ? 33'(-s1_num) : 33'(s1_num);
        s1_dmag      = dn[31] ? 32'(-{dn[31], dn}) : 32'(dn);
        s1_pay.tlo   = s0_data_reg[223:192];
        s1_pay.thi   = s0_data_reg[255:224];
        s1_pay.axis  = s1_axis;
        s1_pay.neg   = s1_num[32] ^ dn[31];
        s1_pay.dzero = (dn == '0);
        s1_pay.front = dn[31];
    end

    logic            s1_vld_reg;
    logic [32:0]     s1_mag_reg;
    logic [31:0]     s1_dmag_reg;
    rari_pkg::tpay_t s1_pay_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg <= s0_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_mag_reg  <= s1_mag;
            s1_dmag_reg <= s1_dmag;
            s1_pay_reg  <= s1_pay;
        end
    end

    // ---------------- t divider ----------------
    logic            td_vld;
    logic [QT-1:0]   td_quo;
    logic [TPW-1:0]  td_pay_bits;
    rari_pkg::tpay_t td_pay;

    rari_div_pipe #(
        .QB (QT),
        .DW (rari_pkg::DIV_DW),
        .PW (TPW)
    ) u_tdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s1_vld_reg),
        .in_rem    ('0),
        .in_bits   ({s1_mag_reg, {FRAC_BITS{1'b0}}}),
        .in_div    ({1'b0, s1_dmag_reg}),
        .in_pay    (TPW'(s1_pay_reg)),
        .out_valid (td_vld),
        .out_quo   (td_quo),
        .out_pay   (td_pay_bits)
    );

    assign td_pay = rari_pkg::tpay_t'(td_pay_bits);

    // ---------------- stage 2: sign and interval test ----------------
    logic signed [QT:0] s2_t;
    logic               s2_in;

    always_comb
    begin
        s2_t  = td_pay.neg ? -$signed({1'b0, td_quo}) : $signed({1'b0, td_quo});
        s2_in = !td_pay.dzero
             && (s2_t >= $signed({{(QT-31){td_pay.tlo[31]}}, td_pay.tlo}))
             && (s2_t <= $signed({{(QT-31){td_pay.thi[31]}}, td_pay.thi}));
    end

    logic               s2_vld_reg;
    logic               s2_ok_reg;
    logic signed [31:0] s2_t_reg;
    rari_pkg::tpay_t    s2_pay_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_vld_reg <= td_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_ok_reg  <= s2_in;
            s2_t_reg   <= s2_t[31:0];
            s2_pay_reg <= td_pay;
        end
    end

    // ---------------- stage 3: direction times t ----------------
    logic               s3_vld_reg;
    logic               s3_ok_reg;
    logic signed [31:0] s3_t_reg;
    logic signed [63:0] s3_pa_reg;
    logic signed [63:0] s3_pb_reg;
    rari_pkg::tpay_t    s3_pay_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_ok_reg  <= s2_ok_reg;
            s3_t_reg   <= s2_t_reg;
            s3_pa_reg  <= s2_pay_reg.da * s2_t_reg;
            s3_pb_reg  <= s2_pay_reg.db * s2_t_reg;
            s3_pay_reg <= s2_pay_reg;
        end
    end

    // ---------------- stage 4: in-plane coordinates ----------------
    logic signed [63:0] s4_sha, s4_shb;

    assign s4_sha = s3_pa_reg >>> FRAC_BITS;
    assign s4_shb = s3_pb_reg >>> FRAC_BITS;

    logic               s4_vld_reg;
    logic               s4_ok_reg;
    logic signed [31:0] s4_t_reg;
    logic signed [64:0] s4_a_reg;
    logic signed [64:0] s4_b_reg;
    rari_pkg::axis_t    s4_axis_reg;
    logic               s4_front_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s4_vld_reg <= s3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_ok_reg    <= s3_ok_reg;
            s4_t_reg     <= s3_t_reg;
            s4_a_reg     <= {{33{s3_pay_reg.oa[31]}}, s3_pay_reg.oa} + {s4_sha[63], s4_sha};
            s4_b_reg     <= {{33{s3_pay_reg.ob[31]}}, s3_pay_reg.ob} + {s4_shb[63], s4_shb};
            s4_axis_reg  <= s3_pay_reg.axis;
            s4_front_reg <= s3_pay_reg.front;
        end
    end

    // ---------------- stage 5: bounds test, span and hit point ----------------
    logic signed [64:0] s5_alo, s5_ahi, s5_blo, s5_bhi;
    logic signed [64:0] s5_na, s5_nb;
    logic [32:0]        s5_span_a, s5_span_b;
    logic [31:0]        s5_sa, s5_sb;
    rari_pkg::upay_t    s5_pay;

    always_comb
    begin
        s5_alo    = 65'(alo_reg);
        s5_ahi    = 65'(ahi_reg);
        s5_blo    = 65'(blo_reg);
        s5_bhi    = 65'(bhi_reg);
        s5_na     = s4_a_reg - s5_alo;
        s5_nb     = s4_b_reg - s5_blo;
        s5_span_a = {ahi_reg[31], ahi_reg} - {alo_reg[31], alo_reg};
        s5_span_b = {bhi_reg[31], bhi_reg} - {blo_reg[31], blo_reg};
        s5_sa     = rari_pkg::sat32(s4_a_reg);
        s5_sb     = rari_pkg::sat32(s4_b_reg);
        s5_pay.tv    = s4_t_reg;
        s5_pay.front = s4_front_reg;
        s5_pay.za    = (s5_span_a == '0);
        s5_pay.ok    = s4_ok_reg
                    && (s4_a_reg >= s5_alo) && (s4_a_reg <= s5_ahi)
                    && (s4_b_reg >= s5_blo) && (s4_b_reg <= s5_bhi);
        unique case (s4_axis_reg)
            rari_pkg::AXIS_X:
            begin
                s5_pay.hx = offset_reg; s5_pay.hy = s5_sa; s5_pay.hz = s5_sb;
            end
            rari_pkg::AXIS_Y:
            begin
                s5_pay.hx = s5_sa; s5_pay.hy = offset_reg; s5_pay.hz = s5_sb;
            end
            default:
            begin
                s5_pay.hx = s5_sa; s5_pay.hy = s5_sb; s5_pay.hz = offset_reg;
            end
        endcase
    end

    logic            s5_vld_reg;
    logic [32:0]     s5_na_reg, s5_nb_reg;
    logic [32:0]     s5_span_a_reg, s5_span_b_reg;
    logic            s5_zb_reg;
    rari_pkg::upay_t s5_pay_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s5_vld_reg <= s4_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_na_reg     <= s5_na[32:0];
            s5_nb_reg     <= s5_nb[32:0];
            s5_span_a_reg <= s5_span_a;
            s5_span_b_reg <= s5_span_b;
            s5_zb_reg     <= (s5_span_b == '0);
            s5_pay_reg    <= s5_pay;
        end
    end

    // ---------------- u and v dividers ----------------
    logic            ud_vld, vd_vld;
    logic [QUV-1:0]  ud_quo, vd_quo;
    logic [UPW-1:0]  ud_pay_bits;
    logic            vd_zb;
    rari_pkg::upay_t ud_pay;

    rari_div_pipe #(
        .QB (QUV),
        .DW (rari_pkg::DIV_DW),
        .PW (UPW)
    ) u_udiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s5_vld_reg),
        .in_rem    ({1'b0, s5_na_reg[32:1]}),
        .in_bits   ({s5_na_reg[0], {rari_pkg::UV_BITS{1'b0}}}),
        .in_div    (s5_span_a_reg),
        .in_pay    (UPW'(s5_pay_reg)),
        .out_valid (ud_vld),
        .out_quo   (ud_quo),
        .out_pay   (ud_pay_bits)
    );

    rari_div_pipe #(
        .QB (QUV),
        .DW (rari_pkg::DIV_DW),
        .PW (1)
    ) u_vdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s5_vld_reg),
        .in_rem    ({1'b0, s5_nb_reg[32:1]}),
        .in_bits   ({s5_nb_reg[0], {rari_pkg::UV_BITS{1'b0}}}),
        .in_div    (s5_span_b_reg),
        .in_pay    (s5_zb_reg),
        .out_valid (vd_vld),
        .out_quo   (vd_quo),
        .out_pay   (vd_zb)
    );

    assign ud_pay = rari_pkg::upay_t'(ud_pay_bits);

    // ---------------- output register ----------------
    logic         out_vld_reg;
    logic [183:0] out_data_reg;
    logic         out_hit_reg;
    logic [183:0] out_data_next;

    assign adv = !out_vld_reg || m_tready;

    always_comb
    begin
        out_data_next = '0;
        if (ud_pay.ok)
        begin
            out_data_next[31:0]    = ud_pay.tv;
            out_data_next[48:32]   = ud_pay.za ? '0 : ud_quo;
            out_data_next[65:49]   = vd_zb ? '0 : vd_quo;
            out_data_next[97:66]   = ud_pay.hx;
            out_data_next[129:98]  = ud_pay.hy;
            out_data_next[161:130] = ud_pay.hz;
            out_data_next[162]     = ud_pay.front;
            out_data_next[178:163] = mat_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_vld_reg <= ud_vld && vd_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= out_data_next;
            out_hit_reg  <= ud_pay.ok;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_hit_reg;

    // ---------------- assertions ----------------
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("miss transaction carries nonzero fields");

    a_u_range: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[48:32] <= 17'd65536 && m_tdata[65:49] <= 17'd65536))
        else $error("u or v above one");

    a_x_plane: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser && axis_reg == rari_pkg::AXIS_X) |-> (m_tdata[97:66] == offset_reg))
        else $error("hit_x differs from plane offset on x-normal plane");

    a_lanes: assert property (@(posedge clk) disable iff (!rst_n)
        ud_vld == vd_vld)
        else $error("u and v divider lanes out of step");

endmodule

@@ rtl/rari_div_pipe.sv @@
// Pipelined restoring divider, one quotient bit per stage, with side payload.
module rari_div_pipe #(
    parameter int QB = 17,
    parameter int DW = 33,
    parameter int PW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  logic          in_valid,
    input  logic [DW-1:0] in_rem,
    input  logic [QB-1:0] in_bits,
    input  logic [DW-1:0] in_div,
    input  logic [PW-1:0] in_pay,
    output logic          out_valid,
    output logic [QB-1:0] out_quo,
    output logic [PW-1:0] out_pay
);

    logic [DW-1:0] rem_reg [QB];
    logic [QB-1:0] bits_reg [QB];
    logic [QB-1:0] quo_reg [QB];
    logic [DW-1:0] div_reg [QB];
    logic [PW-1:0] pay_reg [QB];
    logic          vld_reg [QB];

    for (genvar k = 0; k < QB; k++)
    begin : g_stage
        logic [DW-1:0] p_rem;
        logic [QB-1:0] p_bits;
        logic [QB-1:0] p_quo;
        logic [DW-1:0] p_div;
        logic [PW-1:0] p_pay;
        logic          p_vld;
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          ge;

        if (k == 0)
        begin : g_first
            assign p_rem  = in_rem;
            assign p_bits = in_bits;
            assign p_quo  = '0;
            assign p_div  = in_div;
            assign p_pay  = in_pay;
            assign p_vld  = in_valid;
        end
        else
        begin : g_next
            assign p_rem  = rem_reg[k-1];
            assign p_bits = bits_reg[k-1];
            assign p_quo  = quo_reg[k-1];
            assign p_div  = div_reg[k-1];
            assign p_pay  = pay_reg[k-1];
            assign p_vld  = vld_reg[k-1];
        end

        // shift in next dividend bit, trial subtract
        assign trial = {p_rem, p_bits[QB-1]};
        assign diff  = trial - {1'b0, p_div};
        assign ge    = (trial >= {1'b0, p_div});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[k] <= p_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
                bits_reg[k] <= {p_bits[QB-2:0], 1'b0};
                quo_reg[k]  <= {p_quo[QB-2:0], ge};
                div_reg[k]  <= p_div;
                pay_reg[k]  <= p_pay;
            end
        end
    end

    assign out_valid = vld_reg[QB-1];
    assign out_quo   = quo_reg[QB-1];
    assign out_pay   = pay_reg[QB-1];

endmodule
